[rtl/core/adx_pkg.sv]
// adx_pkg: shared types, widths and codes of the directional index trader
`default_nettype none
package adx_pkg;

  localparam int PRICE_W = 24;
  localparam int FRAC_W  = 16;
  localparam int NUM_W   = 64;
  localparam int DEN_W   = 48;
  localparam int CNT_W   = 7;
  localparam int AVG_W   = 42;
  localparam int RAT_W   = 40;
  localparam int IDX_W   = 24;
  localparam int UNIT_W  = 11;
  localparam int CASH_W  = 48;
  localparam int CFG_W   = 24;

  localparam logic [16:0]      W_ONE     = 17'd65536;
  localparam logic [RAT_W-1:0] RATIO_MAX = 40'h7F_FFFF_FFFF;
  localparam logic [IDX_W-1:0] DX_MAX    = 24'd6553600;

  localparam logic signed [CASH_W-1:0] CASH_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [CASH_W-1:0] CASH_MIN = 48'sh8000_0000_0000;

  // register indexes
  localparam logic [1:0] REG_EMA_WEIGHT     = 2'd0;
  localparam logic [1:0] REG_ADX_THRESHOLD  = 2'd1;
  localparam logic [1:0] REG_POSITION_LIMIT = 2'd2;

  // order codes
  localparam logic [1:0] ORDER_NONE = 2'd0;
  localparam logic [1:0] ORDER_BUY  = 2'd1;
  localparam logic [1:0] ORDER_SELL = 2'd2;

  // day phase codes
  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_ONE  = 2'd1;
  localparam logic [1:0] PH_RUN  = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_TR, CMD_AVG, CMD_DIV_P, CMD_DIV_M, CMD_RATIO,
    CMD_SUMS, CMD_DIV_X, CMD_DX, CMD_ADX, CMD_TRADE, CMD_VALUE, CMD_PUSH
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TR, ST_AVG, ST_DIV_P, ST_WAIT_P, ST_DIV_M, ST_WAIT_M, ST_RATIO,
    ST_SUMS, ST_DIV_X, ST_WAIT_X, ST_DX, ST_ADX, ST_TRADE, ST_VALUE, ST_PUSH
  } state_e;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic phase_zero;
    logic out_free;
  } status_t;

  // saturate a 49-bit signed sum to 48 bits
  function automatic logic signed [CASH_W-1:0] sat48(input logic signed [CASH_W:0] v);
    logic signed [CASH_W-1:0] r;
    if (v[CASH_W] != v[CASH_W-1]) begin
      r = v[CASH_W] ? CASH_MIN : CASH_MAX;
    end else begin
      r = v[CASH_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/adx_div.sv]
// adx_div: restoring divider, one quotient bit per cycle
`default_nettype none
module adx_div
  import adx_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quo_o
);

  logic [DEN_W:0]   rem_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   trial;
  logic             ge;

  // shift in next numerator bit and try a subtract
  always_comb begin
    trial = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
    ge    = trial >= {1'b0, den_q};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      quo_q <= num_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

[rtl/core/adx_dp.sv]
// adx_dp: datapath with indicator state, trade book and output register
`default_nettype none
module adx_dp
  import adx_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cmd_e                     cmd_i,
  output status_t                       status_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [1:0]               cfg_index_i,
  input  wire logic [CFG_W-1:0]         cfg_wdata_i,
  input  wire logic [PRICE_W-1:0]       bar_high_i,
  input  wire logic [PRICE_W-1:0]       bar_low_i,
  input  wire logic [PRICE_W-1:0]       bar_close_i,
  input  wire logic                     out_ready_i,
  output logic                          out_valid_o,
  output logic signed [IDX_W-1:0]       adx_value_o,
  output logic signed [IDX_W-1:0]       dx_value_o,
  output logic [1:0]                    order_kind_o,
  output logic signed [UNIT_W-1:0]      position_o,
  output logic signed [CASH_W-1:0]      cash_balance_o,
  output logic signed [CASH_W-1:0]      closing_value_o
);

  // configuration
  logic [16:0]              ema_q;
  logic signed [IDX_W-1:0]  thr_q;
  logic [9:0]               lim_q;

  // bar and state
  logic [PRICE_W-1:0]       h_q, l_q, c_q, lh_q, ll_q, lc_q;
  logic [1:0]               phase_q;
  logic signed [AVG_W-1:0]  avg_q, trx_q;
  logic signed [AVG_W:0]    avg_diff_q;
  logic signed [RAT_W-1:0]  pr_q, mr_q, rp_q;
  logic signed [IDX_W-1:0]  adx_q, dx_q;
  logic signed [UNIT_W-1:0] units_q;
  logic signed [CASH_W-1:0] cash_q;
  logic                     avg_neg_q, avg_zero_q;
  logic [47:0]              nm100_q;
  logic [DEN_W-1:0]         dm_q;
  logic                     dx_neg_q, sum_zero_q;
  logic [1:0]               kind_q;
  logic signed [35:0]       mtm_q;

  // output register
  logic                     out_valid_q;
  logic signed [IDX_W-1:0]  o_adx_q, o_dx_q;
  logic [1:0]               o_kind_q;
  logic signed [UNIT_W-1:0] o_pos_q;
  logic signed [CASH_W-1:0] o_cash_q, o_close_q;

  // divider
  logic                     div_start, div_busy, div_done;
  logic [NUM_W-1:0]         div_num, div_quo;
  logic [DEN_W-1:0]         div_den;

  // helpers
  logic signed [25:0]       hs, ls, lcs, t1, t2, t3, tr;
  logic [PRICE_W-1:0]       dmp, dmm;
  logic [16:0]              w_eff;
  logic signed [17:0]       ws;
  logic signed [AVG_W-1:0]  trx;
  logic [AVG_W-1:0]         avg_mag;
  logic signed [60:0]       prod_avg;
  logic [RAT_W-1:0]         q40;
  logic signed [RAT_W-1:0]  ratio_new;
  logic signed [RAT_W:0]    pd, md;
  logic signed [RAT_W:0]    diff, sum;
  logic [RAT_W:0]           nm, dmag;
  logic [IDX_W-1:0]         qx;
  logic signed [IDX_W-1:0]  dx_new;
  logic signed [IDX_W:0]    ad;
  logic signed [42:0]       prod_adx;
  logic signed [11:0]       lim_s, us;
  logic                     buy, sell;
  logic signed [CASH_W:0]   cash_sub, cash_add, close_sum;

  // true range and directional moves
  always_comb begin
    hs  = $signed({2'b00, h_q});
    ls  = $signed({2'b00, l_q});
    lcs = $signed({2'b00, lc_q});
    t1  = hs - ls;
    t2  = hs - lcs;
    t3  = ls - lcs;
    tr  = t1;
    if (t2 > tr) tr = t2;
    if (t3 > tr) tr = t3;
    dmp = (h_q > lh_q) ? (h_q - lh_q) : '0;
    dmm = (l_q > ll_q) ? (l_q - ll_q) : '0;
    trx = {tr, {FRAC_W{1'b0}}};
  end

  // weight clamp and average products
  always_comb begin
    w_eff    = (ema_q > W_ONE) ? W_ONE : ema_q;
    ws       = $signed({1'b0, w_eff});
    prod_avg = avg_diff_q * ws;
    avg_mag  = avg_q[AVG_W-1] ? AVG_W'(-avg_q) : avg_q;
    ad       = {dx_q[IDX_W-1], dx_q} - {adx_q[IDX_W-1], adx_q};
    prod_adx = ad * ws;
  end

  // ratio from quotient with cap, zero and sign
  always_comb begin
    q40 = (div_quo > NUM_W'(RATIO_MAX)) ? RATIO_MAX : div_quo[RAT_W-1:0];
    if (avg_zero_q) begin
      ratio_new = '0;
    end else if (avg_neg_q) begin
      ratio_new = -$signed(q40);
    end else begin
      ratio_new = $signed(q40);
    end
    pd = {rp_q[RAT_W-1], rp_q} - {pr_q[RAT_W-1], pr_q};
    md = {ratio_new[RAT_W-1], ratio_new} - {mr_q[RAT_W-1], mr_q};
    diff = {pr_q[RAT_W-1], pr_q} - {mr_q[RAT_W-1], mr_q};
    sum  = {pr_q[RAT_W-1], pr_q} + {mr_q[RAT_W-1], mr_q};
    nm   = diff[RAT_W] ? (RAT_W+1)'(-diff) : diff;
    dmag = sum[RAT_W] ? (RAT_W+1)'(-sum) : sum;
  end

  // directional index from quotient
  always_comb begin
    qx = (div_quo > NUM_W'(DX_MAX)) ? DX_MAX : div_quo[IDX_W-1:0];
    if (sum_zero_q) begin
      dx_new = '0;
    end else if (dx_neg_q) begin
      dx_new = -$signed(qx);
    end else begin
      dx_new = $signed(qx);
    end
  end

  // trade decision and cash
  always_comb begin
    lim_s     = $signed({2'b00, lim_q});
    us        = {units_q[UNIT_W-1], units_q};
    buy       = (dx_q != '0) && (adx_q > thr_q) && (us < lim_s);
    sell      = (dx_q != '0) && !buy && (adx_q < thr_q) && (us > -lim_s);
    cash_sub  = {cash_q[CASH_W-1], cash_q} - $signed({25'd0, c_q});
    cash_add  = {cash_q[CASH_W-1], cash_q} + $signed({25'd0, c_q});
    close_sum = {cash_q[CASH_W-1], cash_q} + (CASH_W+1)'(mtm_q);
  end

  // divider operands
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd_i)
      CMD_DIV_P: begin
        div_start = 1'b1;
        div_num   = {8'd0, dmp, 32'd0};
        div_den   = DEN_W'(avg_mag);
      end
      CMD_DIV_M: begin
        div_start = 1'b1;
        div_num   = {8'd0, dmm, 32'd0};
        div_den   = DEN_W'(avg_mag);
      end
      CMD_DIV_X: begin
        div_start = 1'b1;
        div_num   = {nm100_q, {FRAC_W{1'b0}}};
        div_den   = dm_q;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  adx_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ema_q <= 17'd8738;
      thr_q <= 24'sd1638400;
      lim_q <= 10'd5;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_EMA_WEIGHT:     ema_q <= cfg_wdata_i[16:0];
        REG_ADX_THRESHOLD:  thr_q <= cfg_wdata_i[IDX_W-1:0];
        REG_POSITION_LIMIT: lim_q <= cfg_wdata_i[9:0];
        default:            ema_q <= ema_q;
      endcase
    end
  end

  // persistent state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NONE;
      units_q <= '0;
      cash_q  <= '0;
      lh_q    <= '0;
      ll_q    <= '0;
      lc_q    <= '0;
    end else begin
      case (cmd_i)
        CMD_LOAD: begin
          if (phase_q == PH_NONE) begin
            lh_q    <= bar_high_i;
            ll_q    <= bar_low_i;
            lc_q    <= bar_close_i;
            phase_q <= PH_ONE;
          end
        end
        CMD_ADX: phase_q <= PH_RUN;
        CMD_TRADE: begin
          lh_q <= h_q;
          ll_q <= l_q;
          lc_q <= c_q;
          if (buy) begin
            units_q <= units_q + 1'b1;
            cash_q  <= sat48(cash_sub);
          end else if (sell) begin
            units_q <= units_q - 1'b1;
            cash_q  <= sat48(cash_add);
          end
        end
        default: phase_q <= phase_q;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        h_q <= bar_high_i;
        l_q <= bar_low_i;
        c_q <= bar_close_i;
      end
      CMD_TR: begin
        trx_q      <= trx;
        avg_diff_q <= {trx[AVG_W-1], trx} - {avg_q[AVG_W-1], avg_q};
      end
      CMD_AVG: begin
        avg_q <= (phase_q == PH_ONE) ? trx_q : (avg_q + prod_avg[57:16]);
      end
      CMD_DIV_P: begin
        avg_neg_q  <= avg_q[AVG_W-1];
        avg_zero_q <= (avg_q == '0);
      end
      CMD_DIV_M: rp_q <= ratio_new;
      CMD_RATIO: begin
        if (phase_q == PH_ONE) begin
          pr_q <= rp_q;
          mr_q <= ratio_new;
        end else begin
          pr_q <= pr_q + pd[RAT_W:1];
          mr_q <= mr_q + md[RAT_W:1];
        end
      end
      CMD_SUMS: begin
        nm100_q    <= nm * 7'd100;
        dm_q       <= DEN_W'(dmag);
        dx_neg_q   <= diff[RAT_W] ^ sum[RAT_W];
        sum_zero_q <= (sum == '0);
      end
      CMD_DX: dx_q <= dx_new;
      CMD_ADX: begin
        adx_q <= (phase_q == PH_ONE) ? dx_q : (adx_q + prod_adx[39:16]);
      end
      CMD_TRADE: kind_q <= buy ? ORDER_BUY : (sell ? ORDER_SELL : ORDER_NONE);
      CMD_VALUE: mtm_q <= units_q * $signed({1'b0, c_q});
      default: kind_q <= kind_q;
    endcase
  end

  // output item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i == CMD_PUSH) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_PUSH) begin
      o_adx_q   <= adx_q;
      o_dx_q    <= dx_q;
      o_kind_q  <= kind_q;
      o_pos_q   <= units_q;
      o_cash_q  <= cash_q;
      o_close_q <= sat48(close_sum);
    end
  end

  assign status_o.div_busy   = div_busy;
  assign status_o.div_done   = div_done;
  assign status_o.phase_zero = (phase_q == PH_NONE);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign adx_value_o     = o_adx_q;
  assign dx_value_o      = o_dx_q;
  assign order_kind_o    = o_kind_q;
  assign position_o      = o_pos_q;
  assign cash_balance_o  = o_cash_q;
  assign closing_value_o = o_close_q;

endmodule
`default_nettype wire

[rtl/core/adx_ctrl.sv]
// adx_ctrl: sequencer that steps the datapath through one bar
`default_nettype none
module adx_ctrl
  import adx_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_e         cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept && !status_i.phase_zero) state_d = ST_TR;
      ST_TR:     state_d = ST_AVG;
      ST_AVG:    state_d = ST_DIV_P;
      ST_DIV_P:  state_d = ST_WAIT_P;
      ST_WAIT_P: if (status_i.div_done) state_d = ST_DIV_M;
      ST_DIV_M:  state_d = ST_WAIT_M;
      ST_WAIT_M: if (status_i.div_done) state_d = ST_RATIO;
      ST_RATIO:  state_d = ST_SUMS;
      ST_SUMS:   state_d = ST_DIV_X;
      ST_DIV_X:  state_d = ST_WAIT_X;
      ST_WAIT_X: if (status_i.div_done) state_d = ST_DX;
      ST_DX:     state_d = ST_ADX;
      ST_ADX:    state_d = ST_TRADE;
      ST_TRADE:  state_d = ST_VALUE;
      ST_VALUE:  state_d = ST_PUSH;
      ST_PUSH:   if (status_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = CMD_NONE;
    case (state_q)
      ST_IDLE:  if (accept) cmd_o = CMD_LOAD;
      ST_TR:    cmd_o = CMD_TR;
      ST_AVG:   cmd_o = CMD_AVG;
      ST_DIV_P: cmd_o = CMD_DIV_P;
      ST_DIV_M: cmd_o = CMD_DIV_M;
      ST_RATIO: cmd_o = CMD_RATIO;
      ST_SUMS:  cmd_o = CMD_SUMS;
      ST_DIV_X: cmd_o = CMD_DIV_X;
      ST_DX:    cmd_o = CMD_DX;
      ST_ADX:   cmd_o = CMD_ADX;
      ST_TRADE: cmd_o = CMD_TRADE;
      ST_VALUE: cmd_o = CMD_VALUE;
      ST_PUSH:  if (status_i.out_free) cmd_o = CMD_PUSH;
      default:  cmd_o = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

[rtl/core/adx_trend_trader.sv]
// adx_trend_trader: top level of the directional index trend trader
//
// Input stream s_axis carries one daily bar (high, low, close in ticks).
// Output stream m_axis carries one result item per bar from the second bar
// on: ADX, DX, position, cash and closing value in tdata, order kind in tuser.
// The first bar after reset is only stored and produces no item.
// Configuration is a write port (cfg_we_i, cfg_index_i, cfg_wdata_i) taken
// at any clock edge with the enable high; write only while the block is idle.
// Each bar after the first runs from accept to a valid result through
// three divisions on one shared restoring divider, each of 64 quotient bits
// followed by a done flag, and twelve datapath steps.
// The first bar is stored at its accept edge; the next bar may follow at once.
// One bar is processed at a time; s_axis_tready_o is high only while idle,
// so a bar after the first is taken only once the previous one is pushed.
// The result sits in an output register, so a new bar is accepted while the
// previous result still waits; if the receiver stalls, the next bar finishes
// and holds before its push until the output register frees up.
// Reset (rst_ni low, asynchronous) clears the position, cash and bar history
// and restores the register defaults.
`default_nettype none
module adx_trend_trader
  import adx_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [23:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // bar_high[23:0], bar_low[47:24], bar_close[71:48]
  input  wire logic [71:0]  s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // adx_value[23:0], dx_value[47:24], position[58:48], cash_balance[106:59],
  // closing_value[154:107], zero fill [159:155]
  output logic [159:0]      m_axis_tdata_o,
  // order_kind[1:0]
  output logic [1:0]        m_axis_tuser_o
);

  cmd_e                     cmd;
  status_t                  status;
  logic signed [IDX_W-1:0]  adx_value, dx_value;
  logic [1:0]               order_kind;
  logic signed [UNIT_W-1:0] position;
  logic signed [CASH_W-1:0] cash_balance, closing_value;

  adx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  adx_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .bar_high_i      (s_axis_tdata_i[23:0]),
    .bar_low_i       (s_axis_tdata_i[47:24]),
    .bar_close_i     (s_axis_tdata_i[71:48]),
    .out_ready_i     (m_axis_tready_i),
    .out_valid_o     (m_axis_tvalid_o),
    .adx_value_o     (adx_value),
    .dx_value_o      (dx_value),
    .order_kind_o    (order_kind),
    .position_o      (position),
    .cash_balance_o  (cash_balance),
    .closing_value_o (closing_value)
  );

  // pack result item
  assign m_axis_tdata_o = {5'd0, closing_value, cash_balance, position, dx_value, adx_value};
  assign m_axis_tuser_o = order_kind;

`ifndef NO_ASSERTIONS
  // a push never overwrites a result still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == CMD_PUSH) |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result pushed over a waiting item");

  // a push always shows a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == CMD_PUSH) |=> m_axis_tvalid_o)
    else $error("pushed result not presented");

  // no new bar taken while a division runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_busy |-> !s_axis_tready_o)
    else $error("input ready during division");
`endif

endmodule
`default_nettype wire

[tb/adx_checker.sv]
// adx_checker: predicts and checks result items of the directional index trader
`timescale 1ns / 1ps
module adx_checker
  import adx_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [23:0]  cfg_wdata_i,
  input  wire logic         s_axis_tvalid_i,
  input  wire logic         s_axis_tready_i,
  input  wire logic [71:0]  s_axis_tdata_i,
  input  wire logic         m_axis_tvalid_i,
  input  wire logic         m_axis_tready_i,
  input  wire logic [159:0] m_axis_tdata_i,
  input  wire logic [1:0]   m_axis_tuser_i,
  output int                errors_o,
  output int                pending_o
);

  typedef struct packed {
    logic [23:0] adx;
    logic [23:0] dx;
    logic [1:0]  kind;
    logic [10:0] pos;
    logic [47:0] cash;
    logic [47:0] value;
  } day_result_t;

  localparam longint unsigned RAT_CAP  = 64'h7F_FFFF_FFFF;
  localparam longint unsigned DX_CAP   = 64'd6553600;
  localparam longint          CASH_TOP = 64'sh7FFF_FFFF_FFFF;
  localparam longint          CASH_BOT = -CASH_TOP - 1;

  // mirrored registers
  longint unsigned weight_q;
  longint          thresh_q;
  longint          limit_q;

  // mirrored state
  longint prev_high, prev_low, prev_close;
  int     phase_q;
  longint range_avg, plus_avg, minus_avg, adx_avg, units, cash;

  day_result_t result_q[$];
  int          errors;

  assign errors_o  = errors;
  assign pending_o = result_q.size();

  // min(floor(n * 2^16 / d), cap)
  function automatic longint unsigned div_capped(longint unsigned n, longint unsigned d,
                                                 longint unsigned cap);
    longint unsigned q, r;
    bit              hit;
    q   = n / d;
    r   = n % d;
    hit = (q > cap);
    for (int i = 0; i < FRAC_W; i++) begin
      if (!hit) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q = q | 64'd1;
        end
        hit = (q > cap);
      end
    end
    return hit ? cap : q;
  endfunction

  // floor(a * w / 2^16)
  function automatic longint scale_w(longint a, longint unsigned w);
    longint hi, lo;
    hi = a >>> FRAC_W;
    lo = a - hi * 65536;
    return hi * longint'(w) + longint'((longint'(lo) * longint'(w)) >>> FRAC_W);
  endfunction

  function automatic longint move_ratio(longint mv, longint rng);
    longint unsigned mag, q;
    if (rng == 0) return 0;
    mag = (rng < 0) ? longint'(-rng) : longint'(rng);
    q   = div_capped(longint'(mv) << FRAC_W, mag, RAT_CAP);
    return (rng < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip48(longint v);
    if (v > CASH_TOP) return CASH_TOP;
    if (v < CASH_BOT) return CASH_BOT;
    return v;
  endfunction

  // one bar through the trading rules
  task automatic trade_day(input longint h, input longint l, input longint c);
    longint          tr, up, dn, rp, rm, diff, sum, dxv, q, cv;
    longint unsigned w, nm, dm;
    day_result_t     r;
    logic [1:0]      kind;
    kind = ORDER_NONE;
    if (phase_q == 0) begin
      prev_high = h; prev_low = l; prev_close = c;
      phase_q = 1;
      return;
    end
    tr = h - l;
    if (h - prev_close > tr) tr = h - prev_close;
    if (l - prev_close > tr) tr = l - prev_close;
    up = (h - prev_high > 0) ? h - prev_high : 0;
    dn = (l - prev_low > 0) ? l - prev_low : 0;
    w  = (weight_q > 65536) ? 65536 : weight_q;
    if (phase_q == 1) range_avg = tr * 65536;
    else range_avg = range_avg + scale_w(tr * 65536 - range_avg, w);
    rp = move_ratio(up, range_avg);
    rm = move_ratio(dn, range_avg);
    if (phase_q == 1) begin
      plus_avg  = rp;
      minus_avg = rm;
    end else begin
      plus_avg  = plus_avg + ((rp - plus_avg) >>> 1);
      minus_avg = minus_avg + ((rm - minus_avg) >>> 1);
    end
    diff = plus_avg - minus_avg;
    sum  = plus_avg + minus_avg;
    if (sum == 0) begin
      dxv = 0;
    end else begin
      nm  = (diff < 0) ? longint'(-diff) : longint'(diff);
      dm  = (sum < 0) ? longint'(-sum) : longint'(sum);
      q   = longint'(div_capped(nm * 100, dm, DX_CAP));
      dxv = ((diff < 0) != (sum < 0)) ? -q : q;
    end
    if (phase_q == 1) adx_avg = dxv;
    else adx_avg = adx_avg + scale_w(dxv - adx_avg, w);
    phase_q = 2;
    // one-unit order against the threshold within the limit
    if (dxv != 0) begin
      if (adx_avg > thresh_q && units < limit_q) begin
        units++;
        cash = clip48(cash - c);
        kind = ORDER_BUY;
      end else if (adx_avg < thresh_q && units > -limit_q) begin
        units--;
        cash = clip48(cash + c);
        kind = ORDER_SELL;
      end
    end
    prev_high = h; prev_low = l; prev_close = c;
    cv      = clip48(cash + units * c);
    r.adx   = adx_avg[23:0];
    r.dx    = dxv[23:0];
    r.kind  = kind;
    r.pos   = units[10:0];
    r.cash  = cash[47:0];
    r.value = cv[47:0];
    result_q = {result_q, r};
  endtask

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    if (errors < 10) $display("mismatch %s: expected %h actual %h", what, want, got);
    errors++;
  endtask

  // watch the channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    day_result_t e;
    if (!rst_ni) begin
      weight_q = 8738; thresh_q = 1638400; limit_q = 5;
      prev_high = 0; prev_low = 0; prev_close = 0; phase_q = 0;
      range_avg = 0; plus_avg = 0; minus_avg = 0; adx_avg = 0;
      units = 0; cash = 0;
      result_q.delete();
      errors = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (result_q.size() == 0) begin
          if (errors < 10) $display("unexpected result item %h", m_axis_tdata_i);
          errors++;
        end else begin
          e = result_q.pop_front();
          if (m_axis_tdata_i[23:0] !== e.adx)
            report("adx", 64'(e.adx), 64'(m_axis_tdata_i[23:0]));
          if (m_axis_tdata_i[47:24] !== e.dx)
            report("dx", 64'(e.dx), 64'(m_axis_tdata_i[47:24]));
          if (m_axis_tuser_i !== e.kind)
            report("order", 64'(e.kind), 64'(m_axis_tuser_i));
          if (m_axis_tdata_i[58:48] !== e.pos)
            report("position", 64'(e.pos), 64'(m_axis_tdata_i[58:48]));
          if (m_axis_tdata_i[106:59] !== e.cash)
            report("cash", 64'(e.cash), 64'(m_axis_tdata_i[106:59]));
          if (m_axis_tdata_i[154:107] !== e.value)
            report("value", 64'(e.value), 64'(m_axis_tdata_i[154:107]));
          if (m_axis_tdata_i[159:155] !== 5'd0)
            report("fill", 64'd0, 64'(m_axis_tdata_i[159:155]));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_EMA_WEIGHT:     weight_q = 64'(cfg_wdata_i[16:0]);
          REG_ADX_THRESHOLD:  thresh_q = longint'($signed(cfg_wdata_i));
          REG_POSITION_LIMIT: limit_q  = 64'(cfg_wdata_i[9:0]);
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        trade_day(longint'(s_axis_tdata_i[23:0]), longint'(s_axis_tdata_i[47:24]),
                  longint'(s_axis_tdata_i[71:48]));
    end
  end

endmodule

[tb/tb_adx_trend_trader.sv]
// tb_adx_trend_trader: stimulus and verdict for the directional index trader
`timescale 1ns / 1ps
module tb_adx_trend_trader
  import adx_pkg::*;
();

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_index_i = '0;
  logic [23:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [71:0]  s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [159:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;
  int           errors, pending;

  bit     quiet = 1'b0;
  bit     long_hold = 1'b0;
  int     cycles = 0;
  longint walk = 1000000;

  adx_trend_trader uut (.*);

  adx_checker u_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .m_axis_tuser_i(m_axis_tuser_o), .errors_o(errors), .pending_o(pending)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 1000000) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver with random stall bursts and one long hold-off
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        m_axis_tready_i = 1'b0;
        repeat (3000) @(negedge clk_i);
        long_hold = 1'b0;
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready_i = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 2);
        m_axis_tready_i = 1'b0;
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  // offer one bar and hold it until taken
  task automatic send_bar(input logic [23:0] h, input logic [23:0] l, input logic [23:0] c);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {c, l, h};
    #1;
    while (!s_axis_tready_o) begin
      @(negedge clk_i);
      #1;
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  // register write once the block has drained
  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    wait (pending == 0);
    repeat (300) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // well-formed bar around a random walk, or raw noise
  task automatic random_bar();
    longint span, h, l, c;
    if ($urandom_range(0, 9) == 0) begin
      send_bar(24'($urandom), 24'($urandom), 24'($urandom));
    end else begin
      span = ($urandom_range(0, 15) == 0) ? 2000000 : 5000;
      walk = walk + longint'($urandom_range(0, 2 * span)) - span;
      if (walk < span) walk = span;
      if (walk > 16777215 - span) walk = 16777215 - span;
      h = walk + $urandom_range(0, span / 4);
      l = walk - $urandom_range(0, span / 4);
      c = $urandom_range(l, h);
      send_bar(h[23:0], l[23:0], c[23:0]);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: first bar, flat days, inverted range, price extremes
    send_bar(24'd1000, 24'd900, 24'd950);
    send_bar(24'd1000, 24'd900, 24'd950);
    send_bar(24'd1000, 24'd1000, 24'd1000);
    send_bar(24'd1000, 24'd1000, 24'd1000);
    send_bar(24'd800, 24'd1200, 24'd1000);
    send_bar(24'd1100, 24'd1300, 24'd900);
    send_bar(24'hFFFFFF, 24'd0, 24'hFFFFFF);
    send_bar(24'd0, 24'd0, 24'd0);
    send_bar(24'd1, 24'd0, 24'd1);
    send_bar(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_bar(24'hFFFFFF, 24'hFFFFFE, 24'hFFFFFF);
    send_bar(24'd5000, 24'd4000, 24'd4500);
    for (int i = 0; i < 6; i++)
      send_bar(24'(5000 + 200 * i), 24'(4800 + 200 * i), 24'(4900 + 200 * i));
    for (int i = 0; i < 6; i++)
      send_bar(24'(7000 - 300 * i), 24'(6500 - 300 * i), 24'(6600 - 300 * i));

    // random phases across register settings
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_EMA_WEIGHT, 24'd0);
          write_reg(REG_ADX_THRESHOLD, 24'd0);
          write_reg(REG_POSITION_LIMIT, 24'd1023);
        end
        1: begin
          write_reg(REG_EMA_WEIGHT, 24'd65536);
          write_reg(REG_ADX_THRESHOLD, -24'sd6553600);
        end
        2: begin
          write_reg(REG_EMA_WEIGHT, 24'hFFFFFF);
          write_reg(REG_ADX_THRESHOLD, 24'd6553600);
          write_reg(REG_POSITION_LIMIT, 24'd1);
        end
        3: begin
          write_reg(REG_EMA_WEIGHT, 24'd8738);
          write_reg(REG_ADX_THRESHOLD, 24'd1638400);
          write_reg(REG_POSITION_LIMIT, 24'd0);
        end
        4: begin
          write_reg(REG_EMA_WEIGHT, 24'($urandom_range(0, 65536)));
          write_reg(REG_ADX_THRESHOLD, 24'($urandom_range(0, 600000) - 300000));
          write_reg(REG_POSITION_LIMIT, 24'd7);
        end
        5: begin
          write_reg(REG_EMA_WEIGHT, 24'd32768);
          write_reg(REG_ADX_THRESHOLD, 24'hFFFFFF);
          write_reg(REG_POSITION_LIMIT, 24'hFFFC00 | 24'd3);
        end
        default: begin
          write_reg(REG_EMA_WEIGHT, 24'd13107);
          write_reg(REG_ADX_THRESHOLD, 24'd0);
          write_reg(REG_POSITION_LIMIT, 24'd2);
        end
      endcase
      for (int i = 0; i < 75; i++) begin
        if (ph == 1 && i == 20) long_hold = 1'b1;
        if (ph == 2 && i == 30) wait (pending == 0);
        if (ph == 6 && i == 15) quiet = 1'b1;
        random_bar();
      end
    end

    // drain
    wait (pending == 0);
    repeat (400) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
